// File: src/tts_pkg.sv
// Shared types and codes for the tick task scheduler table.
package tts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 16;
  localparam int unsigned RESULT_LIMIT   = 16;
  localparam int unsigned CNT_W          = $clog2(RESULT_LIMIT + 1);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_DISP = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_ident;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic [3:0]  slot_number;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_out;
    logic [7:0] task_out;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic tick;
    logic del;
    logic add;
    logic disp;
    logic kill;
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic [7:0] task_id;
    logic       del_valid;
  } cell_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_e;

endpackage

// File: src/tts_cell.sv
// One task slot of the scheduler chain with its pass-along token.
module tts_cell import tts_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctl_t      ctl_i,
  input  logic      tok_i,
  output logic      tok_o,
  output cell_out_t out_o
);

  localparam logic       SEL_OK = (IDX < 16);
  localparam logic [3:0] ID4    = 4'(IDX);

  logic        valid_q, valid_d;
  logic [7:0]  task_q, task_d;
  logic [15:0] delay_q, delay_d;
  logic [15:0] period_q, period_d;
  logic [7:0]  pend_q, pend_d;
  logic        tok_q, tok_d;

  logic del_hit, add_hit, disp_hit;

  always_comb begin
    del_hit  = ctl_i.del && SEL_OK && (ctl_i.cmd.slot_number == ID4);
    add_hit  = tok_q && ctl_i.add && !valid_q;
    disp_hit = tok_q && ctl_i.disp && (pend_q != 8'd0);
    tok_o    = tok_q && ((ctl_i.add && valid_q) || ctl_i.disp);
    tok_d    = tok_i && !ctl_i.kill;

    out_o.hit       = add_hit || disp_hit;
    out_o.slot      = (add_hit || disp_hit) ? ID4 : 4'd0;
    out_o.task_id   = disp_hit ? task_q : 8'd0;
    out_o.del_valid = del_hit && valid_q;
  end

  always_comb begin
    valid_d  = valid_q;
    task_d   = task_q;
    delay_d  = delay_q;
    period_d = period_q;
    pend_d   = pend_q;
    if (ctl_i.tick && valid_q) begin
      if (delay_q == 16'd0) begin
        if (pend_q != 8'hFF) begin
          pend_d = pend_q + 8'd1;
        end
        if (period_q != 16'd0) begin
          delay_d = period_q;
        end
      end else begin
        delay_d = delay_q - 16'd1;
      end
    end
    if (add_hit) begin
      valid_d  = 1'b1;
      task_d   = ctl_i.cmd.task_ident;
      delay_d  = ctl_i.cmd.start_delay;
      period_d = ctl_i.cmd.repeat_period;
      pend_d   = 8'd0;
    end
    if (disp_hit) begin
      pend_d = pend_q - 8'd1;
    end
    if (del_hit || (disp_hit && period_q == 16'd0)) begin
      valid_d  = 1'b0;
      task_d   = 8'd0;
      delay_d  = 16'd0;
      period_d = 16'd0;
      pend_d   = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      task_q   <= 8'd0;
      delay_q  <= 16'd0;
      period_q <= 16'd0;
      pend_q   <= 8'd0;
      tok_q    <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      task_q   <= task_d;
      delay_q  <= delay_d;
      period_q <= period_d;
      pend_q   <= pend_d;
      tok_q    <= tok_d;
    end
  end

endmodule

// File: src/tick_task_scheduler_table.sv
// Top level of the tick task scheduler table: sequencer and chain of slot cells.
//
//  channel  | signals                        | handshake
//  ---------+--------------------------------+-------------------------------
//  command  | cmd_i (cmd_t)                  | taken when start && !busy
//  result   | result_o (result_t)            | one cycle, result_valid_o
//
// Tick and delete pass through ST_EXEC. Add walks a token down the slot chain,
// one slot a cycle, to the first free slot. Dispatch walks the whole chain,
// or stops after the sixteenth result. Each result appears on a cycle of its
// own; the receiver cannot stall. Reset empties every slot at once.
module tick_task_scheduler_table import tts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    result_valid_o,
  output result_t result_o
);

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  result_t held_q, held_d;
  logic    held_v_q, held_v_d;
  result_t out_q, out_d;
  logic    strobe_q, strobe_d;

  ctl_t      ctl;
  logic      accept, inject, scan_end, limit_hit;
  logic      tok_link [TASK_SLOTS+1];
  cell_out_t cell_out [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] hit_vec;
  cell_out_t agg;
  result_t   disp_res;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign inject = accept && (cmd_i.opcode == OP_ADD || cmd_i.opcode == OP_DISP);

  assign tok_link[0] = inject;
  assign scan_end    = tok_link[TASK_SLOTS];

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    tts_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .tok_i  (tok_link[i]),
      .tok_o  (tok_link[i+1]),
      .out_o  (cell_out[i])
    );
    assign hit_vec[i] = cell_out[i].hit;
  end

  always_comb begin
    agg = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      agg = agg | cell_out[i];
    end
  end

  assign limit_hit = agg.hit && (cnt_q == CNT_W'(RESULT_LIMIT - 1));

  always_comb begin
    disp_res          = '0;
    disp_res.kind     = KIND_DISP;
    disp_res.slot_out = agg.slot;
    disp_res.task_out = agg.task_id;
    disp_res.status   = STAT_OK;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = inject ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      ST_SCAN: begin
        if (cmd_q.opcode == OP_ADD) begin
          if (agg.hit || scan_end) begin
            state_d = ST_IDLE;
          end
        end else if (limit_hit || scan_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    out_d    = out_q;
    strobe_d = 1'b0;
    ctl      = '0;
    ctl.cmd  = cmd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          cnt_d    = '0;
          held_v_d = 1'b0;
        end
      end
      ST_EXEC: begin
        ctl.tick = (cmd_q.opcode == OP_TICK);
        ctl.del  = (cmd_q.opcode == OP_DEL);
        if (cmd_q.opcode == OP_DEL) begin
          out_d          = '0;
          out_d.kind     = KIND_DEL;
          out_d.slot_out = cmd_q.slot_number;
          out_d.status   = agg.del_valid ? STAT_OK : STAT_EMPTY;
          out_d.last     = 1'b1;
          strobe_d       = 1'b1;
        end
      end
      ST_SCAN: begin
        ctl.add  = (cmd_q.opcode == OP_ADD);
        ctl.disp = (cmd_q.opcode == OP_DISP);
        if (cmd_q.opcode == OP_ADD) begin
          if (agg.hit || scan_end) begin
            out_d          = '0;
            out_d.kind     = KIND_ADD;
            out_d.slot_out = agg.hit ? agg.slot : 4'd0;
            out_d.status   = agg.hit ? STAT_OK : STAT_FULL;
            out_d.last     = 1'b1;
            strobe_d       = 1'b1;
          end
        end else if (agg.hit) begin
          ctl.kill = limit_hit;
          if (held_v_q) begin
            out_d      = held_q;
            out_d.last = 1'b0;
            strobe_d   = 1'b1;
          end
          held_d   = disp_res;
          held_v_d = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (held_v_q) begin
          out_d      = held_q;
          out_d.last = 1'b1;
          strobe_d   = 1'b1;
        end
        held_v_d = 1'b0;
        cnt_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      held_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      held_v_q <= held_v_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign result_valid_o = strobe_q;
  assign result_o       = out_q;

  a_no_hit_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (hit_vec == '0))
    else $error("slot cell reports a result while the sequencer is idle");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one slot cell holds the token");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RESULT_LIMIT))
    else $error("dispatch result count beyond its limit");

  a_add_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmd_q.opcode == OP_ADD && agg.hit)
      |=> (result_valid_o && result_o.last && result_o.kind == KIND_ADD))
    else $error("claimed slot not answered in the next cycle");

endmodule
